// ===== hw/rtl/rrss_pkg.sv =====
// ----------------------------------------------------------------------------
// rrss_pkg: shared types and constants of the round-robin sleep scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rrss_pkg;
  localparam int unsigned MaxThreads = 16;
  localparam int unsigned SlotW = $clog2(MaxThreads);
  localparam int unsigned CntW = $clog2(MaxThreads + 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_TICK = 3'd1, OP_SLEEP = 3'd2, OP_KILL = 3'd3, OP_PREEMPT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RC_DONE = 2'd0, RC_FULL = 2'd1, RC_NOREADY = 2'd2, RC_NOLIVE = 2'd3
  } rc_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DC_NONE, DC_LOAD, DC_SCAN_FREE, DC_PRED_STEP, DC_WALK_STEP, DC_TICK_STEP,
    DC_ADD_LINK, DC_SLEEP_SET, DC_KILL_UNLINK, DC_SET_CUR_SUCC, DC_TIME_INC
  } dcmd_e;

  typedef struct packed {
    dcmd_e cmd;
    logic  start_walk;   // Reset walk pointer to successor of running slot.
  } ctl_t;

  typedef struct packed {
    logic             full;        // live count at capacity
    logic             empty;       // no live thread
    logic             last_live;   // exactly one live thread
    logic             free_found;  // scan pointer on a free slot
    logic             pred_found;  // pred pointer's successor is running slot
    logic             ready_hit;   // walk pointer on a ready slot
    logic             walk_done;   // walk exhausted live count
    logic             sweep_last;  // tick sweep at final slot
  } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/round_robin_sleep_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler: ring-based thread scheduler with sleep timers.
// ----------------------------------------------------------------------------
// Each command transaction yields one result transaction. Add scans for the
// lowest free slot and then walks the ring for the running thread's
// predecessor, kill walks for the predecessor and then the ring for a ready
// thread, sleep and preempt walk the ring one slot per cycle, and tick sweeps
// all slots one per cycle. One command is in flight at a time; the result
// register holds until taken.
`default_nettype none
module round_robin_sleep_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [2:0] opcode, [34:3] sleep_ms
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // [1:0] result_code, [5:2] running_slot,
                                          // [9:6] added_slot, [41:10] ms_time
);
  import rrss_pkg::*;

  ctl_t             ctl;
  sts_t             sts;
  logic [SlotW-1:0] cur, free_slot;
  logic [31:0]      ms_time;
  logic [1:0]       rc;
  logic             add_ok;

  rrss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tdata[2:0]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .rc_o       (rc),
    .add_ok_o   (add_ok),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  rrss_datapath u_dp (
    .clk_i, .rst_ni,
    .ctl_i      (ctl),
    .sleep_ms_i (s_axis_tdata[34:3]),
    .sts_o      (sts),
    .cur_o      (cur),
    .free_o     (free_slot),
    .time_o     (ms_time)
  );

  // The sleep length is captured by the datapath at the accepting edge, so
  // the upstream may change tdata as soon as the command is taken.
  assign m_axis_tdata = {6'd0, ms_time, (add_ok ? free_slot : 4'd0), cur, rc};
endmodule
`default_nettype wire

// ===== hw/rtl/rrss_datapath.sv =====
// ----------------------------------------------------------------------------
// rrss_datapath: slot tables, pointers and time counter of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
module rrss_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rrss_pkg::ctl_t        ctl_i,
  input  wire logic [31:0]           sleep_ms_i,
  output rrss_pkg::sts_t             sts_o,
  output logic [rrss_pkg::SlotW-1:0] cur_o,
  output logic [rrss_pkg::SlotW-1:0] free_o,
  output logic [31:0]                time_o
);
  import rrss_pkg::*;

  logic [SlotW-1:0] ring_next_q [MaxThreads];
  logic [31:0]      sleep_q [MaxThreads];
  logic [MaxThreads-1:0] used_q;
  logic [CntW-1:0]  live_q;
  logic [SlotW-1:0] cur_q, scan_q, pred_q, walk_q;
  logic [CntW-1:0]  steps_q;
  logic [31:0]      time_q;
  logic [31:0]      ms_q;
  logic [SlotW-1:0] succ;

  assign succ = ring_next_q[cur_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      live_q  <= '0;
      cur_q   <= '0;
      time_q  <= '0;
      scan_q  <= '0;
      pred_q  <= '0;
      walk_q  <= '0;
      steps_q <= '0;
      ms_q    <= '0;
    end else begin
      if (ctl_i.start_walk) begin
        walk_q  <= succ;
        steps_q <= '0;
      end
      case (ctl_i.cmd)
        DC_LOAD: begin
          scan_q <= '0;
          pred_q <= cur_q;
          ms_q   <= sleep_ms_i;
        end
        DC_SCAN_FREE: scan_q <= scan_q + SlotW'(1);
        DC_PRED_STEP: pred_q <= ring_next_q[pred_q];
        DC_WALK_STEP: begin
          if (used_q[walk_q] && sleep_q[walk_q] == 32'd0) begin
            cur_q <= walk_q;
          end else begin
            walk_q  <= ring_next_q[walk_q];
            steps_q <= steps_q + CntW'(1);
          end
        end
        DC_TICK_STEP: begin
          if (used_q[scan_q] && sleep_q[scan_q] != 32'd0) begin
            sleep_q[scan_q] <= sleep_q[scan_q] - 32'd1;
          end
          scan_q <= scan_q + SlotW'(1);
        end
        DC_ADD_LINK: begin
          sleep_q[scan_q] <= '0;
          used_q[scan_q]  <= 1'b1;
          live_q          <= live_q + CntW'(1);
          if (live_q == '0) begin
            ring_next_q[scan_q] <= scan_q;
            cur_q               <= scan_q;
          end else begin
            ring_next_q[pred_q] <= scan_q;
            ring_next_q[scan_q] <= cur_q;
          end
        end
        DC_SLEEP_SET: sleep_q[cur_q] <= ms_q;
        DC_KILL_UNLINK: begin
          ring_next_q[pred_q] <= succ;
          used_q[cur_q]       <= 1'b0;
          live_q              <= live_q - CntW'(1);
          walk_q              <= succ;
          steps_q             <= '0;
        end
        DC_SET_CUR_SUCC: cur_q <= walk_q;
        DC_TIME_INC: time_q <= time_q + 32'd1;
        default: ;
      endcase
    end
  end

  // After kill, the walk covers the remaining live threads, starting at the successor.
  always_comb begin
    sts_o.full       = (live_q == CntW'(MaxThreads));
    sts_o.empty      = (live_q == '0);
    sts_o.last_live  = (live_q == CntW'(1));
    sts_o.free_found = !used_q[scan_q];
    sts_o.pred_found = (ring_next_q[pred_q] == cur_q);
    sts_o.ready_hit  = used_q[walk_q] && (sleep_q[walk_q] == 32'd0);
    sts_o.walk_done  = (steps_q >= live_q) && (live_q != '0 || steps_q != '0);
    sts_o.sweep_last = (scan_q == SlotW'(MaxThreads - 1));
  end

  assign cur_o  = cur_q;
  assign free_o = scan_q;
  assign time_o = time_q;
endmodule
`default_nettype wire

// ===== hw/rtl/rrss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrss_ctrl: command sequencer and result register of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
module rrss_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [2:0]     opcode_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          rc_o,
  output logic                add_ok_o,
  output rrss_pkg::ctl_t      ctl_o,
  input  wire rrss_pkg::sts_t sts_i
);
  import rrss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_PRED, S_WALK, S_TICK, S_KPRED, S_KWALK, S_DONE
  } state_e;

  state_e     state_q;
  op_e        op_q;
  logic [1:0] rc_q;
  logic       add_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign rc_o        = rc_q;
  assign add_ok_o    = add_q;

  always_comb begin
    ctl_o.cmd        = DC_NONE;
    ctl_o.start_walk = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i) ctl_o.cmd = DC_LOAD;
      S_DISPATCH: begin
        case (op_q)
          OP_TICK:  ctl_o.cmd = DC_TIME_INC;
          OP_SLEEP: begin
            if (!sts_i.empty) begin
              ctl_o.cmd = DC_SLEEP_SET;
              ctl_o.start_walk = 1'b1;
            end
          end
          OP_PREEMPT: ctl_o.start_walk = !sts_i.empty;
          default: ;
        endcase
      end
      S_SCAN: if (!sts_i.free_found) ctl_o.cmd = DC_SCAN_FREE;
      S_PRED: begin
        if (sts_i.empty || sts_i.pred_found) ctl_o.cmd = DC_ADD_LINK;
        else ctl_o.cmd = DC_PRED_STEP;
      end
      S_WALK:  if (!sts_i.walk_done) ctl_o.cmd = DC_WALK_STEP;
      S_TICK:  ctl_o.cmd = DC_TICK_STEP;
      S_KPRED: begin
        if (sts_i.pred_found) ctl_o.cmd = DC_KILL_UNLINK;
        else ctl_o.cmd = DC_PRED_STEP;
      end
      S_KWALK: begin
        if (sts_i.walk_done) ctl_o.cmd = DC_SET_CUR_SUCC;
        else ctl_o.cmd = DC_WALK_STEP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      rc_q    <= RC_DONE;
      add_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_e'(opcode_i);
            rc_q    <= RC_DONE;
            add_q   <= 1'b0;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op_q)
            OP_ADD: begin
              if (sts_i.full) begin
                rc_q <= RC_FULL;
                state_q <= S_DONE;
              end else state_q <= S_SCAN;
            end
            OP_TICK: state_q <= S_TICK;
            OP_SLEEP, OP_PREEMPT: begin
              if (sts_i.empty) begin
                rc_q <= RC_NOLIVE;
                state_q <= S_DONE;
              end else state_q <= S_WALK;
            end
            OP_KILL: begin
              if (sts_i.empty) begin
                rc_q <= RC_NOLIVE;
                state_q <= S_DONE;
              end else state_q <= S_KPRED;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_SCAN: if (sts_i.free_found) state_q <= S_PRED;
        S_PRED: begin
          if (sts_i.empty || sts_i.pred_found) begin
            add_q   <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_WALK: begin
          if (sts_i.walk_done) begin
            rc_q <= RC_NOREADY;
            state_q <= S_DONE;
          end else if (sts_i.ready_hit) state_q <= S_DONE;
        end
        S_TICK: if (sts_i.sweep_last) state_q <= S_DONE;
        S_KPRED: begin
          if (sts_i.pred_found) begin
            if (sts_i.last_live) begin
              rc_q <= RC_NOLIVE;
              state_q <= S_DONE;
            end else state_q <= S_KWALK;
          end
        end
        S_KWALK: begin
          if (sts_i.walk_done) begin
            rc_q <= RC_NOREADY;
            state_q <= S_DONE;
          end else if (sts_i.ready_hit) state_q <= S_DONE;
        end
        S_DONE: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_DISPATCH)
    else $error("accepted command not dispatched");
  a_add_rc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && add_q) |-> rc_q == RC_DONE) else $error("added with error code");
endmodule
`default_nettype wire
